[hdl/dabd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabd_pkg
// Shared widths, channel codes, register indexes and the records that pass
// between the front end, the queues and the box decoder.
// ----------------------------------------------------------------------------
package dabd_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_CLASSES = 255;
    localparam int QDEPTH      = 2;

    localparam int VALUE_W = 32;
    localparam int CLASS_W = 8;
    localparam int CONF_W  = 31;
    localparam int THR_W   = 17;
    localparam int NET_W   = 13;
    localparam int IDX_W   = 9;
    localparam int LEFT_W  = 12 + FRAC_BITS;  // up to (4096 - 1) px
    localparam int SIZE_W  = 13 + FRAC_BITS;  // up to 4096 px
    localparam int WIDE_W  = VALUE_W + 1;     // signed working width of the decoder

    // channel positions within one anchor
    localparam logic [IDX_W-1:0] CH_CX   = IDX_W'(0);
    localparam logic [IDX_W-1:0] CH_CY   = IDX_W'(1);
    localparam logic [IDX_W-1:0] CH_W    = IDX_W'(2);
    localparam logic [IDX_W-1:0] CH_H    = IDX_W'(3);
    localparam logic [IDX_W-1:0] CH_CLS0 = IDX_W'(4);

    // register indexes on the configuration port
    localparam logic [1:0] REG_NUM_CLASSES = 2'd0;
    localparam logic [1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_NET_WIDTH   = 2'd2;
    localparam logic [1:0] REG_NET_HEIGHT  = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0]        class_id;
        logic [CONF_W-1:0]         confidence;
        logic signed [VALUE_W-1:0] cx;
        logic signed [VALUE_W-1:0] cy;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] h;
    } t_box_req;

    typedef struct packed {
        logic [CLASS_W-1:0]        class_id;
        logic [CONF_W-1:0]         confidence;
        logic [LEFT_W-1:0]         left;
        logic [LEFT_W-1:0]         top;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] h;
    } t_box_corner;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [CONF_W-1:0]  confidence;
        logic [LEFT_W-1:0]  left;
        logic [LEFT_W-1:0]  top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_box_res;

endpackage
`default_nettype wire

[hdl/dabd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabd_fifo
// Small first-in first-out queue of packed records, of any depth.
// ----------------------------------------------------------------------------
module dabd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[hdl/dabd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabd_front
// Channel counter, box capture and running argmax over the class scores;
// hands a box request downstream when an anchor ends at or above threshold.
// ----------------------------------------------------------------------------
module dabd_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic signed [dabd_pkg::VALUE_W-1:0] i_value,
    input  wire logic        [dabd_pkg::CLASS_W-1:0] i_num_classes,
    input  wire logic        [dabd_pkg::THR_W-1:0]   i_threshold,
    output logic                                     o_req_push,
    output dabd_pkg::t_box_req                       o_req
);
    import dabd_pkg::*;

    logic        [IDX_W-1:0]   r_idx;
    logic signed [VALUE_W-1:0] r_cx;
    logic signed [VALUE_W-1:0] r_cy;
    logic signed [VALUE_W-1:0] r_w;
    logic signed [VALUE_W-1:0] r_h;
    logic signed [VALUE_W-1:0] r_best;
    logic        [CLASS_W-1:0] r_cls;
    logic                      r_found;

    logic [CLASS_W-1:0]        nc;
    logic [IDX_W-1:0]          last;
    logic                      is_end;
    logic                      upd;
    logic signed [VALUE_W-1:0] thr_ext;
    logic                      v_pass;
    logic                      best_pass;
    logic signed [VALUE_W-1:0] n_best;
    logic [CLASS_W-1:0]        n_cls;
    logic                      n_found;
    logic                      n_pass;
    logic [IDX_W-1:0]          cls_idx;

    assign nc      = (i_num_classes > CLASS_W'(MAX_CLASSES)) ? CLASS_W'(MAX_CLASSES)
                                                             : i_num_classes;
    assign last    = {1'b0, nc} + CH_H;
    assign is_end  = (r_idx >= last);
    assign cls_idx = r_idx - CH_CLS0;

    // test the new score and the held best against the live threshold side by side
    assign upd       = (r_idx >= CH_CLS0) && (i_value > r_best);
    assign thr_ext   = $signed({{(VALUE_W - THR_W){1'b0}}, i_threshold});
    assign v_pass    = (i_value >= thr_ext);
    assign best_pass = (r_best >= thr_ext);
    assign n_best    = upd ? i_value : r_best;
    assign n_cls     = upd ? cls_idx[CLASS_W-1:0] : r_cls;
    assign n_found   = upd || r_found;
    assign n_pass    = upd ? v_pass : best_pass;

    assign o_req_push       = i_accept && is_end && n_found && n_pass;
    assign o_req.class_id   = n_cls;
    assign o_req.confidence = n_best[CONF_W-1:0];
    assign o_req.cx         = r_cx;
    assign o_req.cy         = r_cy;
    assign o_req.w          = r_w;
    assign o_req.h          = (r_idx == CH_H) ? i_value : r_h;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            priority if (r_idx == CH_CX) begin
                r_cx <= i_value;
            end else if (r_idx == CH_CY) begin
                r_cy <= i_value;
            end else if (r_idx == CH_W) begin
                r_w <= i_value;
            end else if (r_idx == CH_H) begin
                r_h <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_best      <= '0;
            r_cls       <= '0;
            r_found     <= 1'b0;
        end else if (i_accept) begin
            if (is_end || r_idx == CH_CX) begin
                // start a fresh anchor
                r_idx       <= is_end ? '0 : r_idx + IDX_W'(1);
                r_best      <= '0;
                r_cls       <= '0;
                r_found     <= 1'b0;
            end else begin
                r_idx       <= r_idx + IDX_W'(1);
                r_best      <= n_best;
                r_cls       <= n_cls;
                r_found     <= n_found;
            end
        end
    end
endmodule
`default_nettype wire

[hdl/dabd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dabd_back
// Box decoder: center to corner with clamping in the first stage, size cut
// to the frame and the minimum size check in the second.
// ----------------------------------------------------------------------------
module dabd_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_req_valid,
    input  wire dabd_pkg::t_box_req                i_req,
    output logic                                   o_req_pop,
    input  wire logic        [dabd_pkg::NET_W-1:0] i_net_width,
    input  wire logic        [dabd_pkg::NET_W-1:0] i_net_height,
    input  wire logic                              i_res_full,
    output logic                                   o_res_push,
    output dabd_pkg::t_box_res                     o_res
);
    import dabd_pkg::*;

    localparam logic signed [WIDE_W-1:0] TWO = WIDE_W'(2) <<< FRAC_BITS;

    logic        r_s1_v;
    t_box_corner r_s1;
    t_box_corner s1_in;

    logic [NET_W-1:0]         fw_px;
    logic [NET_W-1:0]         fh_px;
    logic [NET_W-1:0]         fw_px_m1;
    logic [NET_W-1:0]         fh_px_m1;
    logic [LEFT_W-1:0]        fw_m1;
    logic [LEFT_W-1:0]        fh_m1;
    logic [SIZE_W-1:0]        fw;
    logic [SIZE_W-1:0]        fh;
    logic signed [VALUE_W+1:0] dx;
    logic signed [VALUE_W+1:0] dy;
    logic signed [WIDE_W-1:0]  half_x;
    logic signed [WIDE_W-1:0]  half_y;
    logic [SIZE_W-1:0]        room_w;
    logic [SIZE_W-1:0]        room_h;
    logic signed [WIDE_W-1:0]  wc;
    logic signed [WIDE_W-1:0]  hc;
    logic                     keep;
    logic                     s1_drain;

    // frame size held to 1..4096 pixels
    always_comb begin
        fw_px = i_net_width;
        fh_px = i_net_height;
        if (fw_px == '0) begin
            fw_px = NET_W'(1);
        end else if (fw_px > NET_W'(4096)) begin
            fw_px = NET_W'(4096);
        end
        if (fh_px == '0) begin
            fh_px = NET_W'(1);
        end else if (fh_px > NET_W'(4096)) begin
            fh_px = NET_W'(4096);
        end
    end

    assign fw_px_m1 = fw_px - NET_W'(1);
    assign fh_px_m1 = fh_px - NET_W'(1);
    assign fw_m1    = {fw_px_m1[NET_W-2:0], {FRAC_BITS{1'b0}}};
    assign fh_m1    = {fh_px_m1[NET_W-2:0], {FRAC_BITS{1'b0}}};
    assign fw       = {fw_px, {FRAC_BITS{1'b0}}};
    assign fh       = {fh_px, {FRAC_BITS{1'b0}}};

    // stage 1: corner = floor(center - size / 2), clamped to the frame
    assign dx     = {i_req.cx[VALUE_W-1], i_req.cx, 1'b0}
                  - {{2{i_req.w[VALUE_W-1]}}, i_req.w};
    assign dy     = {i_req.cy[VALUE_W-1], i_req.cy, 1'b0}
                  - {{2{i_req.h[VALUE_W-1]}}, i_req.h};
    assign half_x = dx[VALUE_W+1:1];
    assign half_y = dy[VALUE_W+1:1];

    always_comb begin
        s1_in.class_id   = i_req.class_id;
        s1_in.confidence = i_req.confidence;
        s1_in.w          = i_req.w;
        s1_in.h          = i_req.h;
        priority if (half_x > $signed({{(WIDE_W - LEFT_W){1'b0}}, fw_m1})) begin
            s1_in.left = fw_m1;
        end else if (half_x < 0) begin
            s1_in.left = '0;
        end else begin
            s1_in.left = half_x[LEFT_W-1:0];
        end
        priority if (half_y > $signed({{(WIDE_W - LEFT_W){1'b0}}, fh_m1})) begin
            s1_in.top = fh_m1;
        end else if (half_y < 0) begin
            s1_in.top = '0;
        end else begin
            s1_in.top = half_y[LEFT_W-1:0];
        end
    end

    // stage 2: cut the size to what is left of the frame
    assign room_w = fw - {1'b0, r_s1.left};
    assign room_h = fh - {1'b0, r_s1.top};

    always_comb begin
        wc = {r_s1.w[VALUE_W-1], r_s1.w};
        hc = {r_s1.h[VALUE_W-1], r_s1.h};
        if (wc > $signed({{(WIDE_W - SIZE_W){1'b0}}, room_w})) begin
            wc = {{(WIDE_W - SIZE_W){1'b0}}, room_w};
        end
        if (hc > $signed({{(WIDE_W - SIZE_W){1'b0}}, room_h})) begin
            hc = {{(WIDE_W - SIZE_W){1'b0}}, room_h};
        end
    end

    assign keep     = (wc > TWO) && (hc > TWO);
    assign s1_drain = r_s1_v && (!keep || !i_res_full);
    assign o_req_pop  = i_req_valid && (!r_s1_v || s1_drain);
    assign o_res_push = r_s1_v && keep && !i_res_full;

    assign o_res.class_id   = r_s1.class_id;
    assign o_res.confidence = r_s1.confidence;
    assign o_res.left       = r_s1.left;
    assign o_res.top        = r_s1.top;
    assign o_res.width      = wc[SIZE_W-1:0];
    assign o_res.height     = hc[SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_s1 <= s1_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (o_req_pop) begin
            r_s1_v <= 1'b1;
        end else if (s1_drain) begin
            r_s1_v <= 1'b0;
        end
    end
endmodule
`default_nettype wire

[hdl/detection_anchor_box_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// detection_anchor_box_decode
// Anchor-free detection box decoder: argmax over class scores, then corner
// conversion, clamping and size cut of the boxes that pass the threshold.
// ----------------------------------------------------------------------------
//  Channel     Direction  Handshake                  Payload
//  values      in         push / full                i_value (signed Q16.16)
//  boxes       out        empty / pop                o_class_id .. o_box_height
//  registers   in/out     psel penable pwrite pready paddr, pwdata, prdata
//
//  One value is taken every cycle while full is low; full rises only when the
//  request queue between the argmax front end and the box decoder is full.
//  A box reaches the result ports through the request queue, the corner
//  stage and the result queue, in that order, each a registered step.
//  Reset is synchronous and active low; it clears the channel count, the
//  argmax and both queues, and loads the register defaults.
//  A stalled result side backs up through the result queue, the corner stage
//  and the request queue before full is raised.
// ----------------------------------------------------------------------------
module detection_anchor_box_decode #(
    parameter int QUEUE_DEPTH = dabd_pkg::QDEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // value stream
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [dabd_pkg::VALUE_W-1:0] i_value,
    // box stream
    output logic                                     empty,
    input  wire logic                                pop,
    output logic        [dabd_pkg::CLASS_W-1:0]      o_class_id,
    output logic        [dabd_pkg::CONF_W-1:0]       o_confidence,
    output logic        [dabd_pkg::LEFT_W-1:0]       o_box_left,
    output logic        [dabd_pkg::LEFT_W-1:0]       o_box_top,
    output logic        [dabd_pkg::SIZE_W-1:0]       o_box_width,
    output logic        [dabd_pkg::SIZE_W-1:0]       o_box_height,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [3:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);
    import dabd_pkg::*;

    // configuration registers
    logic [CLASS_W-1:0] r_num_classes;
    logic [THR_W-1:0]   r_threshold;
    logic [NET_W-1:0]   r_net_width;
    logic [NET_W-1:0]   r_net_height;
    logic               cfg_wr;

    // front end to request queue
    logic     accept;
    logic     req_push;
    t_box_req req_in;
    logic     req_full;
    logic     req_empty;
    logic     req_pop;
    t_box_req req_out;

    // decoder to result queue
    logic     res_push;
    t_box_res res_in;
    logic     res_full;
    t_box_res res_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= CLASS_W'(80);
            r_threshold   <= THR_W'(16384);
            r_net_width   <= NET_W'(640);
            r_net_height  <= NET_W'(640);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_NUM_CLASSES: r_num_classes <= pwdata[CLASS_W-1:0];
                REG_THRESHOLD:   r_threshold   <= pwdata[THR_W-1:0];
                REG_NET_WIDTH:   r_net_width   <= pwdata[NET_W-1:0];
                REG_NET_HEIGHT:  r_net_height  <= pwdata[NET_W-1:0];
                default:         r_num_classes <= r_num_classes;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_CLASSES: prdata = {{(32 - CLASS_W){1'b0}}, r_num_classes};
            REG_THRESHOLD:   prdata = {{(32 - THR_W){1'b0}}, r_threshold};
            REG_NET_WIDTH:   prdata = {{(32 - NET_W){1'b0}}, r_net_width};
            REG_NET_HEIGHT:  prdata = {{(32 - NET_W){1'b0}}, r_net_height};
            default:         prdata = '0;
        endcase
    end

    // hold off the value stream only while the request queue is full
    assign full   = req_full;
    assign accept = push && !full;

    dabd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_value       (i_value),
        .i_num_classes (r_num_classes),
        .i_threshold   (r_threshold),
        .o_req_push    (req_push),
        .o_req         (req_in)
    );

    dabd_fifo #(
        .WIDTH ($bits(t_box_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_push),
        .i_data  (req_in),
        .o_full  (req_full),
        .i_pop   (req_pop),
        .o_empty (req_empty),
        .o_data  (req_out)
    );

    dabd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (!req_empty),
        .i_req        (req_out),
        .o_req_pop    (req_pop),
        .i_net_width  (r_net_width),
        .i_net_height (r_net_height),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // result queue: the oldest box waits on the ports until its transfer
    dabd_fifo #(
        .WIDTH ($bits(t_box_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_class_id   = res_out.class_id;
    assign o_confidence = res_out.confidence;
    assign o_box_left   = res_out.left;
    assign o_box_top    = res_out.top;
    assign o_box_width  = res_out.width;
    assign o_box_height = res_out.height;

`ifndef SYNTHESIS
    // a request is never offered to a full request queue
    a_req_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_push |-> !req_full)
        else $error("box request pushed into a full queue");

    // the decoder never offers a box to a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("box pushed into a full result queue");

    // every box shown is wider and taller than two pixels
    a_min_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_box_width > (SIZE_W'(2) << FRAC_BITS))
                && (o_box_height > (SIZE_W'(2) << FRAC_BITS)))
        else $error("box below minimum size on the result ports");

    // the request queue only drains into the decoder when it holds an entry
    a_req_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_pop |-> !req_empty)
        else $error("request taken from an empty queue");
`endif
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anchor box decoder. Values are pushed anchor by
// anchor, a local predictor runs the argmax and the corner/clamp/size-cut
// arithmetic on every accepted value, and each box taken from the result side
// is compared field by field with the oldest predicted box. Directed anchors
// cover the score and size boundaries and the register extremes, then three
// random streams run with different register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import dabd_pkg::*;

    localparam int SETTLE_CYCLES = 8;       // settle time once no box is pending; keep a margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_VALUES  = 310;

    // ------------------------------------------------------------------------
    // DUT signals, every input driven to a known value from time zero
    // ------------------------------------------------------------------------
    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push    = 1'b0;
    logic                      full;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      empty;
    logic                      pop     = 1'b0;
    logic [CLASS_W-1:0]        o_class_id;
    logic [CONF_W-1:0]         o_confidence;
    logic [LEFT_W-1:0]         o_box_left;
    logic [LEFT_W-1:0]         o_box_top;
    logic [SIZE_W-1:0]         o_box_width;
    logic [SIZE_W-1:0]         o_box_height;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [3:0]                paddr   = '0;
    logic [31:0]               pwdata  = '0;
    logic [31:0]               prdata;
    logic                      pready;

    detection_anchor_box_decode u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_class_id   (o_class_id),
        .o_confidence (o_confidence),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies and the per-anchor argmax
    // ------------------------------------------------------------------------
    logic [7:0]         cfg_classes = 8'd80;
    logic [THR_W-1:0]   cfg_thr     = 17'd16384;
    logic [NET_W-1:0]   cfg_width   = 13'd640;
    logic [NET_W-1:0]   cfg_height  = 13'd640;

    logic [IDX_W-1:0]   chan_pos    = '0;
    longint             anchor_cx   = 0;
    longint             anchor_cy   = 0;
    longint             anchor_w    = 0;
    longint             anchor_h    = 0;
    longint             top_score   = 0;
    logic [CLASS_W-1:0] top_class   = '0;
    bit                 have_class  = 1'b0;

    t_box_res           pending_boxes[$];   // predicted boxes, oldest first
    int                 values_sent    = 0;
    int                 err_count      = 0;
    int                 cycle_count    = 0;
    int unsigned        send_idle_pct  = 22;
    int unsigned        recv_idle_pct  = 55;

    function automatic longint frame_fix(logic [NET_W-1:0] n);
        longint m;
        m = longint'(n);
        if (m < 1)    m = 1;
        if (m > 4096) m = 4096;
        return m <<< FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] to_q16(int pixels);
        return pixels <<< FRAC_BITS;
    endfunction

    // Advance the anchor by one value; return 1 and the box when one is due.
    function automatic bit decode_value(input logic signed [31:0] v, output t_box_res box);
        longint val, last_chan, one, fw, fh, left, top, w, h;
        val       = longint'(v);
        box       = '0;
        one       = longint'(1) <<< FRAC_BITS;
        last_chan = 3 + ((cfg_classes > MAX_CLASSES) ? MAX_CLASSES : longint'(cfg_classes));

        case (chan_pos)
            CH_CX: begin
                anchor_cx  = val;
                top_score  = 0;
                top_class  = '0;
                have_class = 1'b0;
            end
            CH_CY: anchor_cy = val;
            CH_W:  anchor_w  = val;
            CH_H:  anchor_h  = val;
            default: begin
                // strictly above zero and above every earlier score: ties keep the first
                if (val > top_score) begin
                    top_score  = val;
                    top_class  = CLASS_W'(chan_pos - CH_CLS0);
                    have_class = 1'b1;
                end
            end
        endcase

        if (longint'(chan_pos) < last_chan) begin
            chan_pos = chan_pos + 1'b1;
            return 1'b0;
        end

        chan_pos   = '0;
        have_class = have_class && (top_score >= longint'(cfg_thr));
        if (!have_class) begin
            top_score = 0;
            top_class = '0;
            return 1'b0;
        end

        fw   = frame_fix(cfg_width);
        fh   = frame_fix(cfg_height);
        // centre to corner, floor on the half
        left = (2 * anchor_cx - anchor_w) >>> 1;
        top  = (2 * anchor_cy - anchor_h) >>> 1;
        if (left > fw - one) left = fw - one;
        if (left < 0)        left = 0;
        if (top > fh - one)  top = fh - one;
        if (top < 0)         top = 0;
        w = (anchor_w > fw - left) ? fw - left : anchor_w;
        h = (anchor_h > fh - top)  ? fh - top  : anchor_h;

        box.class_id   = top_class;
        box.confidence = CONF_W'(top_score);
        box.left       = LEFT_W'(left);
        box.top        = LEFT_W'(top);
        box.width      = SIZE_W'(w);
        box.height     = SIZE_W'(h);

        have_class = 1'b0;
        top_score  = 0;
        top_class  = '0;
        return (w > 2 * one) && (h > 2 * one);
    endfunction

    // ------------------------------------------------------------------------
    // Value side: hold push until the transfer, then predict
    // ------------------------------------------------------------------------
    task automatic push_value(input logic signed [31:0] v);
        t_box_res box;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_value <= v;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        values_sent++;
        if (decode_value(v, box)) begin
            pending_boxes.insert(pending_boxes.size(), box);
        end
    endtask

    task automatic push_box_channels(input logic signed [31:0] cx, input logic signed [31:0] cy,
                                     input logic signed [31:0] w, input logic signed [31:0] h);
        push_value(cx);
        push_value(cy);
        push_value(w);
        push_value(h);
    endtask

    // Drop push, let every predicted box out and give the pipe time to empty.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic read_reg(input logic [1:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] readback;
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        stored = '0;
        case (idx)
            REG_NUM_CLASSES: begin cfg_classes = data[7:0];       stored = 32'(cfg_classes); end
            REG_THRESHOLD:   begin cfg_thr     = data[THR_W-1:0]; stored = 32'(cfg_thr);     end
            REG_NET_WIDTH:   begin cfg_width   = data[NET_W-1:0]; stored = 32'(cfg_width);   end
            REG_NET_HEIGHT:  begin cfg_height  = data[NET_W-1:0]; stored = 32'(cfg_height);  end
            default: ;
        endcase
        read_reg(idx, readback);
        if (readback !== stored) begin
            err_count++;
            $display("%0t: register %0d readback, expected 0x%0h actual 0x%0h",
                     $time, idx, stored, readback);
        end
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
        write_reg(REG_NET_WIDTH, w);
        write_reg(REG_NET_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Box side: check each transfer, then stall at random
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            err_count++;
            $display("%0t: box %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : box_check
        t_box_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_boxes.size() == 0) begin
                err_count++;
                $display("%0t: box with none predicted, expected none actual class 0x%0h",
                         $time, o_class_id);
            end else begin
                want = pending_boxes.pop_front();
                check_field("class_id",   want.class_id,   o_class_id);
                check_field("confidence", want.confidence, o_confidence);
                check_field("left",       want.left,       o_box_left);
                check_field("top",        want.top,        o_box_top);
                check_field("width",      want.width,      o_box_width);
                check_field("height",     want.height,     o_box_height);
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** detection_anchor_box_decode: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_register_defaults();
        logic [31:0] got;
        logic [31:0] want[4];
        want = '{32'd80, 32'd16384, 32'd640, 32'd640};
        for (int i = 0; i < 4; i++) begin
            read_reg(2'(i), got);
            if (got !== want[i]) begin
                err_count++;
                $display("%0t: register %0d after reset, expected 0x%0h actual 0x%0h",
                         $time, i, want[i], got);
            end
        end
    endtask

    // One class per anchor: threshold edges, the 2.0 size floor, clamping, extremes.
    task automatic test_score_and_size_edges();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd1);
        // odd lsb on the width: floor on the half corner
        push_box_channels(to_q16(100), to_q16(100), to_q16(50) + 1, to_q16(40));
        push_value(32'h0000_8000);
        // right edge cut, top clamped to zero, score exactly at threshold
        push_box_channels(to_q16(630), to_q16(-5), to_q16(40), to_q16(40));
        push_value(32'(cfg_thr));
        // one lsb under the threshold
        push_box_channels(to_q16(100), to_q16(100), to_q16(50), to_q16(40));
        push_value(32'(cfg_thr) - 1);
        // width exactly 2.0 is dropped, one lsb more passes
        push_box_channels(to_q16(100), to_q16(100), 32'h0002_0000, to_q16(40));
        push_value(32'h0001_0000);
        push_box_channels(to_q16(100), to_q16(100), 32'h0002_0001, 32'h0002_0001);
        push_value(32'h0001_0000);
        // negative width with extreme centres
        push_box_channels(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_value(32'h7FFF_FFFF);
        // most negative centre, largest size: whole frame at top confidence
        push_box_channels(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_value(32'h7FFF_FFFF);
    endtask

    // A zero score is never chosen; an equal score keeps the earlier class.
    task automatic test_score_ties();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd3);
        push_box_channels(to_q16(320), to_q16(240), to_q16(64), to_q16(48));
        push_value(32'h0000_0000);
        push_value(32'h0000_8000);
        push_value(32'h0000_8000);
    endtask

    // No class channels: the anchor ends on the height and never gives a box.
    task automatic test_zero_classes();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd0);
        push_box_channels(to_q16(100), to_q16(100), to_q16(50), to_q16(50));
        push_box_channels(32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Shrink the class count in mid-anchor: the next value closes the anchor.
    task automatic test_class_count_change();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd10);
        push_box_channels(to_q16(200), to_q16(200), to_q16(60), to_q16(60));
        push_value(32'h0000_1999);
        push_value(32'h0000_9999);
        push_value(32'h0000_3333);
        push_value(32'h0000_4CCC);
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd2);
        push_value(32'h0000_E666);
        // a full anchor to show the count is back in step
        push_box_channels(to_q16(50), to_q16(60), to_q16(30), to_q16(20));
        push_value(32'h0000_6000);
        push_value(32'h0000_5000);
    endtask

    // Frame sizes at and beyond both ends of their range.
    task automatic test_frame_extremes();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd1);
        write_reg(REG_THRESHOLD, 32'd0);
        set_frame(32'd0, 32'd0);
        push_box_channels(to_q16(10), to_q16(10), to_q16(10), to_q16(10));
        push_value(32'h0001_0000);
        wait_drained();
        set_frame(32'd1, 32'd4096);
        push_box_channels(to_q16(0), to_q16(2000), to_q16(4), to_q16(300));
        push_value(32'h0001_0000);
        wait_drained();
        set_frame(32'd8191, 32'd4096);
        push_box_channels(to_q16(4200), to_q16(4000), to_q16(400), to_q16(300));
        push_value(32'h0001_0000);
        push_box_channels(to_q16(5000), to_q16(100), to_q16(100), to_q16(100));
        push_value(32'h0001_0000);
        // one lsb of score clears a zero threshold
        push_box_channels(to_q16(2048), to_q16(2048), to_q16(4095), to_q16(4095) + 1);
        push_value(32'h0000_0001);
    endtask

    // Full class count with the last class winning, highest threshold.
    task automatic test_class_extremes();
        wait_drained();
        write_reg(REG_NUM_CLASSES, 32'd255);
        write_reg(REG_THRESHOLD, 32'h1_FFFF);
        set_frame(32'd640, 32'd640);
        push_box_channels(to_q16(320), to_q16(320), to_q16(100), to_q16(100));
        for (int k = 0; k < 254; k++) push_value(32'h0001_0000 + k * 256);
        push_value(32'h7FFF_FFFF);
        // same count, best score just under the highest threshold
        push_box_channels(to_q16(320), to_q16(320), to_q16(100), to_q16(100));
        for (int k = 0; k < 255; k++) push_value((k == 77) ? 32'h0001_FFFE : 32'h0000_1000);
    endtask

    function automatic logic signed [31:0] rand_position(int span_px);
        return ($urandom_range(span_px + 64) << FRAC_BITS) + $urandom_range(16'hFFFF)
               - (32 << FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] rand_size(int span_px);
        int unsigned pick;
        pick = $urandom_range(99);
        if (span_px > 400) span_px = 400;
        if (pick < 15) return $urandom_range(4 << FRAC_BITS);   // around the 2.0 floor
        if (pick < 20) return 32'd0 - $urandom_range(1 << 24);
        return ($urandom_range(span_px) << FRAC_BITS) + $urandom_range(16'hFFFF);
    endfunction

    // Mostly plausible anchors; some built from corner values, some pure noise.
    task automatic push_random_anchor();
        int unsigned        mode;
        int                 fw_px;
        int                 fh_px;
        logic signed [31:0] v;
        logic signed [31:0] last_score;
        mode       = $urandom_range(99);
        fw_px      = int'(frame_fix(cfg_width) >>> FRAC_BITS);
        fh_px      = int'(frame_fix(cfg_height) >>> FRAC_BITS);
        last_score = '0;
        for (int k = 0; k < 4 + int'(cfg_classes); k++) begin
            if (mode >= 85) begin
                v = $urandom;
            end else if (mode >= 70) begin
                case ($urandom_range(7))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h7FFF_FFFF;
                    4: v = 32'h8000_0000;
                    5: v = 32'h0002_0000;
                    6: v = 32'h0002_0001;
                    default: v = 32'(cfg_thr);
                endcase
            end else begin
                case (IDX_W'(k))
                    CH_CX: v = rand_position(fw_px);
                    CH_CY: v = rand_position(fh_px);
                    CH_W:  v = rand_size(fw_px);
                    CH_H:  v = rand_size(fh_px);
                    default: begin
                        // now and then repeat the previous score to make a tie
                        if (k > 4 && $urandom_range(9) == 0) v = last_score;
                        else v = $urandom_range(163840) - 32768;
                        last_score = v;
                    end
                endcase
            end
            push_value(v);
        end
    endtask

    task automatic test_random_stream(input int nc, input int thr, input int nw, input int nh,
                                      input int unsigned send_pct, input int unsigned recv_pct);
        int first_value;
        wait_drained();
        write_reg(REG_NUM_CLASSES, nc);
        write_reg(REG_THRESHOLD, thr);
        set_frame(nw, nh);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_value   = values_sent;
        while (values_sent - first_value < PHASE_VALUES) begin
            push_random_anchor();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_defaults();
        test_score_and_size_edges();
        test_score_ties();
        test_zero_classes();
        test_class_count_change();
        test_frame_extremes();
        test_class_extremes();
        test_random_stream(6, 16384, 640, 480, 22, 55);
        test_random_stream(1, 65536, 1920, 1080, 55, 22);
        test_random_stream(20, 32768, 416, 256, 0, 0);

        wait_drained();
        if (err_count == 0) begin
            $display("** detection_anchor_box_decode: PASSED **");
        end else begin
            $display("** detection_anchor_box_decode: FAILED **");
        end
        $finish;
    end

endmodule
